### sv/amse_pkg.sv
// ----------------------------------------------------------------------------
// amse_pkg
// Shared types, constants and helpers of the 2-D transform matrix stack.
// ----------------------------------------------------------------------------
`default_nettype none
package amse_pkg;
	localparam int STACK_DEPTH = 16;
	localparam int FRAC_BITS   = 16;
	localparam int LVL_W       = $clog2(STACK_DEPTH);
	localparam int ELEMS       = 9;
	localparam int RAM_DEPTH   = STACK_DEPTH * 3;
	localparam int ADDR_W      = $clog2(RAM_DEPTH);
	localparam int ROW_W       = 96;
	localparam int PROD_W      = 64 - FRAC_BITS;
	localparam int SUM_W       = PROD_W + 2;

	localparam logic [2:0] REQ_IDENTITY = 3'd0;
	localparam logic [2:0] REQ_PUSH     = 3'd1;
	localparam logic [2:0] REQ_POP      = 3'd2;
	localparam logic [2:0] REQ_COMPOSE  = 3'd3;
	localparam logic [2:0] REQ_APPLY    = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sh0000_0000_7FFF_FFFF);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sh0000_0000_8000_0000);

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m20;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic [1:0]         status;
		logic [3:0]         level;
	} out_item_t;

	// Floor-shifted product of two fixed-point elements (arithmetic shift floors).
	function automatic logic signed [PROD_W-1:0] fx_mul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p[63:FRAC_BITS] ;
	endfunction

	// Saturate a wide sum into signed 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		if (v > SAT_HI) return 32'sh7FFF_FFFF;
		if (v < SAT_LO) return 32'sh8000_0000;
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

### sv/amse_ram.sv
// ----------------------------------------------------------------------------
// amse_ram
// Generic single-port-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module amse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### sv/amse_lane.sv
// ----------------------------------------------------------------------------
// amse_lane
// One column lane: three floor-shifted products of one row by one column,
// registered, then summed and saturated.
// ----------------------------------------------------------------------------
`default_nettype none
module amse_lane (
	input  wire                clk,
	input  wire signed [31:0]  a0,
	input  wire signed [31:0]  a1,
	input  wire signed [31:0]  a2,
	input  wire signed [31:0]  b0,
	input  wire signed [31:0]  b1,
	input  wire signed [31:0]  b2,
	output logic signed [31:0] res
);
	localparam int PW = amse_pkg::PROD_W;
	localparam int SW = amse_pkg::SUM_W;

	logic signed [PW-1:0] p0_s1, p1_s1, p2_s1;
	logic signed [SW-1:0] sum;

	// Register products
	always_ff @(posedge clk) begin
		p0_s1 <= amse_pkg::fx_mul(a0, b0);
		p1_s1 <= amse_pkg::fx_mul(a1, b1);
		p2_s1 <= amse_pkg::fx_mul(a2, b2);
	end

	// Sum and saturate
	assign sum = SW'(p0_s1) + SW'(p1_s1) + SW'(p2_s1);
	assign res = amse_pkg::sat32(sum);
endmodule
`default_nettype wire

### sv/affine_matrix_stack_engine.sv
// ----------------------------------------------------------------------------
// affine_matrix_stack_engine
// Stack of 3x3 Q16.16 transform matrices with identity, push, pop, compose
// and point apply.
// ----------------------------------------------------------------------------
// Usage: an item enters on in_valid/in_ready carrying the request and its
// operands; one result item leaves on out_valid/out_ready with out_x, out_y,
// status and the top level after the step. The stack lives in a RAM of one
// 96-bit row per matrix row. An item that needs the top matrix reads its
// three rows through the registered read, then for compose three column
// lanes form one output row per cycle and write it back. One item is in
// work at a time and in_ready is high only when the engine is idle and the
// output register is empty or being taken, so a new item is accepted only
// once the previous one is done. While the receiver stalls, the result
// holds in the output register and no item is accepted.
// Reset empties the stack to level zero; level zero's identity is served by
// a flag until the first write to it, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module affine_matrix_stack_engine (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  amse_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  wire                  out_ready,
	output amse_pkg::out_item_t  out_item
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_CALC = 3'd2;
	localparam logic [2:0] S_DONE = 3'd3;

	localparam int LW = amse_pkg::LVL_W;
	localparam int AW = amse_pkg::ADDR_W;
	localparam int RW = amse_pkg::ROW_W;

	logic [2:0]          state_q;
	amse_pkg::in_item_t  req_q;
	logic [LW-1:0]       top_q;
	logic                base_id_q;
	logic [1:0]          rcnt_q;   // rows issued
	logic [1:0]          gcnt_q;   // rows captured
	logic [1:0]          wcnt_q;   // rows computed
	logic                rd_pend_q;
	logic signed [31:0]  t_q [amse_pkg::ELEMS];
	logic signed [31:0]  ox_q, oy_q;
	logic [1:0]          st_q;

	logic                we;
	logic [AW-1:0]       waddr, raddr;
	logic [RW-1:0]       wdata, rdata;
	logic signed [31:0]  la0, la1, la2;
	logic signed [31:0]  lr [3];
	logic [1:0]          lrow_s1;
	logic                lval_s1;
	logic                needs_mat;
	logic [LW-1:0]       dst_lvl;
	logic                rd_pend_d;
	logic                lval_d;
	logic [3:0]          wbase;
	logic [3:0]          gbase;

	amse_ram #(.WIDTH(amse_pkg::ROW_W), .DEPTH(amse_pkg::RAM_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign needs_mat = (req_q.req_type == amse_pkg::REQ_COMPOSE) ||
		(req_q.req_type == amse_pkg::REQ_APPLY) ||
		(req_q.req_type == amse_pkg::REQ_PUSH &&
		 top_q != LW'(amse_pkg::STACK_DEPTH - 1));
	assign in_ready = (state_q == S_IDLE) && !out_valid ||
		(state_q == S_IDLE && out_ready);
	assign raddr = AW'(top_q) * AW'(3) + AW'(rcnt_q);
	assign wbase = 4'(wcnt_q) * 4'd3;
	assign gbase = 4'(gcnt_q) * 4'd3;

	// Next read-pending and lane-valid flags
	assign rd_pend_d = (state_q == S_READ) && needs_mat && (rcnt_q != 2'd3);
	assign lval_d = (state_q == S_CALC) &&
		(((req_q.req_type == amse_pkg::REQ_COMPOSE) && (wcnt_q != 2'd3)) ||
		 ((req_q.req_type == amse_pkg::REQ_APPLY) && !lval_s1 && (wcnt_q == 2'd0)));

	// Lane operands: compose uses row i of M against columns of T;
	// apply uses rows of T against (px, py, 1) with row 2 ignored.
	always_comb begin
		la0 = req_q.m00; la1 = req_q.m01; la2 = req_q.m02;
		if (req_q.req_type == amse_pkg::REQ_COMPOSE) begin
			case (wcnt_q)
				2'd1: begin la0 = req_q.m10; la1 = req_q.m11; la2 = req_q.m12; end
				2'd2: begin la0 = req_q.m20; la1 = req_q.m21; la2 = req_q.m22; end
				default: ;
			endcase
		end
	end

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_lane
			logic signed [31:0] b0, b1, b2, a0, a1, a2;
			always_comb begin
				if (req_q.req_type == amse_pkg::REQ_APPLY) begin
					a0 = t_q[g*3]; a1 = t_q[g*3+1]; a2 = amse_pkg::FX_ONE;
					b0 = req_q.point_x; b1 = req_q.point_y; b2 = t_q[g*3+2];
				end else begin
					a0 = la0; a1 = la1; a2 = la2;
					b0 = t_q[g]; b1 = t_q[3+g]; b2 = t_q[6+g];
				end
			end
			amse_lane u_lane (
				.clk(clk), .a0(a0), .a1(a1), .a2(a2),
				.b0(b0), .b1(b1), .b2(b2), .res(lr[g])
			);
		end
	endgenerate

	// Write port: identity rows, push copy, compose rows
	assign dst_lvl = (req_q.req_type == amse_pkg::REQ_PUSH) ? top_q + LW'(1) : top_q;
	always_comb begin
		we = 1'b0;
		wdata = '0;
		waddr = AW'(dst_lvl) * AW'(3) + AW'(wcnt_q);
		if (state_q == S_CALC) begin
			unique case (req_q.req_type)
				amse_pkg::REQ_IDENTITY: begin
					we = 1'b1;
					wdata = {(wcnt_q == 2'd0) ? amse_pkg::FX_ONE : 32'sd0,
						(wcnt_q == 2'd1) ? amse_pkg::FX_ONE : 32'sd0,
						(wcnt_q == 2'd2) ? amse_pkg::FX_ONE : 32'sd0};
				end
				amse_pkg::REQ_PUSH: begin
					we = needs_mat;
					wdata = {t_q[wbase], t_q[wbase + 4'd1], t_q[wbase + 4'd2]};
				end
				amse_pkg::REQ_COMPOSE: begin
					we = lval_s1;
					waddr = AW'(top_q) * AW'(3) + AW'(lrow_s1);
					wdata = {lr[0], lr[1], lr[2]};
				end
				default: ;
			endcase
		end
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			top_q     <= '0;
			base_id_q <= 1'b1;
			out_valid <= 1'b0;
			rcnt_q    <= '0;
			gcnt_q    <= '0;
			wcnt_q    <= '0;
			rd_pend_q <= 1'b0;
			lval_s1   <= 1'b0;
			lrow_s1   <= '0;
		end else begin
			rd_pend_q <= rd_pend_d;
			lval_s1   <= lval_d;
			if (state_q == S_DONE && (!out_valid || out_ready))
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= S_READ;
						rcnt_q <= '0; gcnt_q <= '0; wcnt_q <= '0;
					end
				end
				S_READ: begin
					if (!needs_mat) begin
						state_q <= S_CALC;
					end else begin
						if (rcnt_q != 2'd3) rcnt_q <= rcnt_q + 2'd1;
						if (rd_pend_q) gcnt_q <= gcnt_q + 2'd1;
						if (rd_pend_q && gcnt_q == 2'd2) state_q <= S_CALC;
					end
				end
				S_CALC: begin
					unique case (req_q.req_type) inside
						amse_pkg::REQ_IDENTITY, amse_pkg::REQ_PUSH: begin
							if (req_q.req_type == amse_pkg::REQ_IDENTITY &&
									top_q == '0)
								base_id_q <= 1'b0;
							if (!needs_mat && req_q.req_type == amse_pkg::REQ_PUSH)
								state_q <= S_DONE;
							else begin
								wcnt_q <= wcnt_q + 2'd1;
								if (wcnt_q == 2'd2) state_q <= S_DONE;
							end
						end
						amse_pkg::REQ_COMPOSE: begin
							if (wcnt_q != 2'd3) begin
								lrow_s1 <= wcnt_q;
								wcnt_q <= wcnt_q + 2'd1;
							end
							if (lval_s1 && lrow_s1 == 2'd2) begin
								state_q <= S_DONE;
								if (top_q == '0) base_id_q <= 1'b0;
							end
						end
						amse_pkg::REQ_APPLY: begin
							wcnt_q <= 2'd1;
							if (lval_s1) state_q <= S_DONE;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						state_q <= S_IDLE;
						if (req_q.req_type == amse_pkg::REQ_PUSH &&
								st_q == amse_pkg::ST_OK)
							top_q <= top_q + LW'(1);
						if (req_q.req_type == amse_pkg::REQ_POP &&
								st_q == amse_pkg::ST_OK)
							top_q <= top_q - LW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the request, rows read and results
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready) begin
			req_q <= in_item;
			ox_q <= '0; oy_q <= '0;
			if (in_item.req_type == amse_pkg::REQ_PUSH &&
					top_q == LW'(amse_pkg::STACK_DEPTH - 1))
				st_q <= amse_pkg::ST_OVERFLOW;
			else if (in_item.req_type == amse_pkg::REQ_POP && top_q == '0)
				st_q <= amse_pkg::ST_UNDERFLOW;
			else
				st_q <= amse_pkg::ST_OK;
		end
		if (state_q == S_READ && rd_pend_q) begin
			for (int k = 0; k < 3; k++) begin
				if (base_id_q && top_q == '0)
					t_q[gbase + 4'(k)] <= (gcnt_q == 2'(k)) ? amse_pkg::FX_ONE : 32'sd0;
				else
					t_q[gbase + 4'(k)] <= rdata[95-32*k -: 32];
			end
		end
		if (state_q == S_CALC && req_q.req_type == amse_pkg::REQ_APPLY && lval_s1) begin
			ox_q <= lr[0];
			oy_q <= lr[1];
		end
	end

	assign out_item.out_x  = ox_q;
	assign out_item.out_y  = oy_q;
	assign out_item.status = st_q;
	assign out_item.level  = 4'(top_q);

	ast_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= LW'(amse_pkg::STACK_DEPTH - 1))
		else $error("top level out of range");
	ast_push_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid == 1'b0 && req_q.req_type == amse_pkg::REQ_PUSH
		 && st_q == amse_pkg::ST_OK) |=> top_q == $past(top_q) + LW'(1))
		else $error("push did not raise level");
	ast_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("accept while busy");
endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed stack requests (identity, push, pop, compose,
// apply and unknown codes) into the transform matrix stack and compares every
// result item against an in-bench model of the stack and its fixed-point sums.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
	localparam int WATCHDOG_LIMIT = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	amse_pkg::in_item_t   in_item;
	logic                 out_valid;
	logic                 out_ready;
	amse_pkg::out_item_t  out_item;

	amse_pkg::in_item_t   pending_q[$];
	amse_pkg::out_item_t  expected_q[$];
	logic signed [31:0] stack_mat[amse_pkg::STACK_DEPTH][9];
	int          stack_top;
	int          errors;
	int          idle_cycles;
	bit          feed_done;
	int          rx_gap;
	int          tx_gap;

	// Registered acceptance seen at the last rising edge
	logic in_ready_s;
	initial in_ready_s = 1'b0;

	affine_matrix_stack_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor-shifted exact product
	function automatic logic signed [63:0] fx_prod(logic signed [31:0] a,
			logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p >>> amse_pkg::FRAC_BITS;
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Advance the stack model by one request and queue its result
	task automatic predict_step(input amse_pkg::in_item_t it);
		logic signed [31:0] m[9];
		logic signed [31:0] r[9];
		amse_pkg::out_item_t res;
		res = '0;
		m = '{it.m00, it.m01, it.m02, it.m10, it.m11, it.m12, it.m20, it.m21, it.m22};
		case (it.req_type)
			amse_pkg::REQ_IDENTITY: begin
				for (int i = 0; i < 9; i++) stack_mat[stack_top][i] = 0;
				stack_mat[stack_top][0] = amse_pkg::FX_ONE;
				stack_mat[stack_top][4] = amse_pkg::FX_ONE;
				stack_mat[stack_top][8] = amse_pkg::FX_ONE;
			end
			amse_pkg::REQ_PUSH: begin
				if (stack_top == amse_pkg::STACK_DEPTH - 1) res.status = amse_pkg::ST_OVERFLOW;
				else begin
					stack_mat[stack_top + 1] = stack_mat[stack_top];
					stack_top++;
				end
			end
			amse_pkg::REQ_POP: begin
				if (stack_top == 0) res.status = amse_pkg::ST_UNDERFLOW;
				else stack_top--;
			end
			amse_pkg::REQ_COMPOSE: begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						r[i*3+j] = clamp32(fx_prod(m[i*3], stack_mat[stack_top][j])
							+ fx_prod(m[i*3+1], stack_mat[stack_top][3+j])
							+ fx_prod(m[i*3+2], stack_mat[stack_top][6+j]));
				stack_mat[stack_top] = r;
			end
			amse_pkg::REQ_APPLY: begin
				res.out_x = clamp32(fx_prod(stack_mat[stack_top][0], it.point_x)
					+ fx_prod(stack_mat[stack_top][1], it.point_y)
					+ 64'(stack_mat[stack_top][2]));
				res.out_y = clamp32(fx_prod(stack_mat[stack_top][3], it.point_x)
					+ fx_prod(stack_mat[stack_top][4], it.point_y)
					+ 64'(stack_mat[stack_top][5]));
			end
			default: ;
		endcase
		res.level = 4'(stack_top);
		expected_q.push_back(res);
	endtask

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			3: return 32'(amse_pkg::FX_ONE);
			default: return 32'($signed($urandom_range(0, 262143)) - 131072);
		endcase
	endfunction

	function automatic amse_pkg::in_item_t rand_item(logic [2:0] req);
		amse_pkg::in_item_t it;
		it.req_type = req;
		it.m00 = rand_elem(); it.m01 = rand_elem(); it.m02 = rand_elem();
		it.m10 = rand_elem(); it.m11 = rand_elem(); it.m12 = rand_elem();
		it.m20 = rand_elem(); it.m21 = rand_elem(); it.m22 = rand_elem();
		it.point_x = rand_elem(); it.point_y = rand_elem();
		return it;
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// Fill the item queue: directed part, then random
	initial begin
		amse_pkg::in_item_t it;
		it = rand_item(amse_pkg::REQ_APPLY);
		it.point_x = 32'h7FFF_FFFF; it.point_y = 32'h8000_0000;
		pending_q.push_back(it);
		pending_q.push_back(rand_item(amse_pkg::REQ_POP));
		pending_q.push_back(rand_item(amse_pkg::REQ_IDENTITY));
		it = rand_item(amse_pkg::REQ_COMPOSE);
		it.m00 = 32'h7FFF_FFFF; it.m01 = 32'h7FFF_FFFF; it.m02 = 32'h7FFF_FFFF;
		it.m10 = 32'h8000_0000; it.m11 = 32'h8000_0000; it.m12 = 32'h8000_0000;
		pending_q.push_back(it);
		it = rand_item(amse_pkg::REQ_APPLY);
		it.point_x = 32'h7FFF_FFFF; it.point_y = 32'h7FFF_FFFF;
		pending_q.push_back(it);
		for (int i = 0; i < 16; i++) pending_q.push_back(rand_item(amse_pkg::REQ_PUSH));
		pending_q.push_back(rand_item(3'd5));
		pending_q.push_back(rand_item(3'd6));
		pending_q.push_back(rand_item(3'd7));
		pending_q.push_back(rand_item(amse_pkg::REQ_APPLY));
		for (int i = 0; i < 1450; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3:         it = rand_item(amse_pkg::REQ_PUSH);
				4, 5, 6, 7:         it = rand_item(amse_pkg::REQ_POP);
				8:                  it = rand_item(amse_pkg::REQ_IDENTITY);
				9, 10, 11, 12, 13:  it = rand_item(amse_pkg::REQ_COMPOSE);
				14:                 it = rand_item(3'($urandom_range(5, 7)));
				default:            it = rand_item(amse_pkg::REQ_APPLY);
			endcase
			pending_q.push_back(it);
		end
	end

	// Reset, then wait for the run to drain
	initial begin
		arst_n = 1'b0;
		errors = 0;
		stack_top = 0;
		for (int l = 0; l < amse_pkg::STACK_DEPTH; l++)
			for (int i = 0; i < 9; i++) stack_mat[l][i] = 0;
		stack_mat[0][0] = amse_pkg::FX_ONE;
		stack_mat[0][4] = amse_pkg::FX_ONE;
		stack_mat[0][8] = amse_pkg::FX_ONE;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (feed_done && expected_q.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0 && !out_valid) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Drive items at the falling edge; hold while not accepted
	int sent;
	bit drained;
	initial begin
		in_valid = 1'b0; in_item = '0; feed_done = 1'b0; tx_gap = 0; sent = 0;
		drained = 1'b0;
	end
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_ready_s)) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				in_valid <= 1'b0;
			end else if (sent == 700 && !drained) begin
				// pause until every result is back
				in_valid <= 1'b0;
				if (expected_q.size() == 0) drained <= 1'b1;
			end else if (pending_q.size() > 0) begin
				in_item <= pending_q.pop_front();
				in_valid <= 1'b1;
				sent <= sent + 1;
				tx_gap <= rand_gap();
			end else begin
				in_valid <= 1'b0;
				feed_done <= 1'b1;
			end
		end
	end

	// Receiver stalls: random gaps plus one long hold-off
	int rx_count;
	initial begin out_ready = 1'b0; rx_gap = 0; rx_count = 0; end
	always @(negedge clk) begin
		if (arst_n) begin
			rx_count <= rx_count + 1;
			if (rx_count == 3000) begin
				rx_gap <= 300;
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				rx_gap <= ($urandom_range(0, 3) == 0) ? rand_gap() : 0;
			end
		end
	end

	// Sample both handshakes, predict and check
	always @(posedge clk) begin
		amse_pkg::out_item_t exp_item;
		in_ready_s <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) predict_step(in_item);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_item);
					errors++;
				end else begin
					exp_item = expected_q.pop_front();
					if (out_item.out_x !== exp_item.out_x)
						$display("%0t: out_x expected %0d actual %0d", $time,
							exp_item.out_x, out_item.out_x);
					if (out_item.out_y !== exp_item.out_y)
						$display("%0t: out_y expected %0d actual %0d", $time,
							exp_item.out_y, out_item.out_y);
					if (out_item.status !== exp_item.status)
						$display("%0t: status expected %0d actual %0d", $time,
							exp_item.status, out_item.status);
					if (out_item.level !== exp_item.level)
						$display("%0t: level expected %0d actual %0d", $time,
							exp_item.level, out_item.level);
					if (out_item !== exp_item) errors++;
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end
endmodule
`default_nettype wire
